FILE: hdl/uid_whitelist_table_macros.svh
// ----------------------------------------------------------------------------
// uid whitelist table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef UID_WHITELIST_TABLE_MACROS_SVH
`define UID_WHITELIST_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UWT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UWT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define UWT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define UWT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/uwt_pkg.sv
// ----------------------------------------------------------------------------
// uwt_pkg
// shared types and constants of the uid whitelist table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uwt_pkg;

   localparam int KIND_W              = 2;
   localparam int ID_W                = 32;
   localparam int STATUS_W            = 2;
   localparam int ENTRY_COUNT_W       = 5;
   localparam int DEFAULT_TABLE_DEPTH = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_STORE  = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // one request travelling down the row of cells
   typedef struct packed {
      logic            valid;
      kind_type        kind;
      logic [ID_W-1:0] card_id;
      logic            registered;
      logic            master;
      logic            found;
   } token_type;

endpackage

`default_nettype wire

FILE: hdl/uwt_cell.sv
// ----------------------------------------------------------------------------
// uwt_cell
// one table slot: compares the passing token and updates its entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uwt_cell
   import uwt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int CELL_INDEX  = 0
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [$clog2(TABLE_DEPTH+1)-1:0]    count,
   input  token_type                           prev_tok,
   output token_type                           tok,
   input  wire  [ID_W-1:0]                     below_entry,
   output logic [ID_W-1:0]                     entry
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] IDX      = CW'(CELL_INDEX);
   localparam logic [CW-1:0] IDX_NEXT = CW'(CELL_INDEX + 1);

   logic [ID_W-1:0] entry_ff, entry_in;
   token_type       tok_ff, tok_in;
   logic            hit;
   logic            in_range;

   always_comb begin
      hit      = (prev_tok.card_id == entry_ff);
      in_range = (IDX < count);
      tok_in   = prev_tok;
      entry_in = entry_ff;
      if (prev_tok.valid) begin
         tok_in.registered = prev_tok.registered | (hit & in_range);
         if (CELL_INDEX == 0) begin
            tok_in.master = hit;
         end
         case (prev_tok.kind)
            KIND_STORE: begin
               if (IDX == count) begin
                  entry_in = prev_tok.card_id;
               end
            end
            KIND_REMOVE: begin
               // from the first match on, every valid slot takes its lower neighbor
               if ((CELL_INDEX != 0) && in_range && (prev_tok.found || hit)) begin
                  tok_in.found = 1'b1;
                  entry_in     = (IDX_NEXT < count) ? below_entry : '0;
               end
            end
            KIND_CLEAR: begin
               if (CELL_INDEX != 0) begin
                  entry_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         entry_ff     <= '0;
      end else begin
         tok_ff   <= tok_in;
         entry_ff <= entry_in;
      end
   end

   assign tok   = tok_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

FILE: hdl/uwt_ctrl.sv
// ----------------------------------------------------------------------------
// uwt_ctrl
// request intake, entry count and result register of the table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uid_whitelist_table_macros.svh"

module uwt_ctrl
   import uwt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [KIND_W-1:0]                   req_kind,
   input  wire  [ID_W-1:0]                     req_card_id,
   output token_type                           tok_head,
   input  token_type                           tok_tail,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]    count,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_is_registered,
   output logic                                rsp_is_master,
   output logic [STATUS_W-1:0]                 rsp_status,
   output logic [ENTRY_COUNT_W-1:0]            rsp_entry_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [CW-1:0]            count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_reg_ff, rsp_mst_ff;
   status_type               rsp_status_ff, status;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   logic                     accept;

   // the result slot is free by the time this beat leaves the chain
   // no beat is taken while reset is held
   assign req_ready = !reset && !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      tok_head            = '0;
      tok_head.valid      = accept;
      tok_head.kind       = kind_type'(req_kind);
      tok_head.card_id    = req_card_id;
   end

   always_comb begin
      count_in = count_ff;
      status   = STATUS_DONE;
      if (tok_tail.valid) begin
         case (tok_tail.kind)
            KIND_STORE: begin
               if (count_ff == DEPTH_C) begin
                  status = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_REMOVE: begin
               if (tok_tail.found) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  status = STATUS_NOT_FOUND;
               end
            end
            KIND_CLEAR: begin
               count_in = CW'(1);
            end
            default: begin
            end
         endcase
      end
      busy_in      = accept ? 1'b1 : (tok_tail.valid ? 1'b0 : busy_ff);
      rsp_valid_in = tok_tail.valid ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_tail.valid) begin
         rsp_reg_ff    <= tok_tail.registered;
         rsp_mst_ff    <= tok_tail.master;
         rsp_status_ff <= status;
         rsp_count_ff  <= ENTRY_COUNT_W'(count_in);
      end
   end

   assign count             = count_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_registered = rsp_reg_ff;
   assign rsp_is_master     = rsp_mst_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `UWT_ASSERT_IMPLY(a_tail_slot_free, clock, reset, tok_tail.valid, !rsp_valid_ff,
      "beat left the chain while the result slot was full")
   `UWT_ASSERT_IMPLY(a_tail_while_busy, clock, reset, tok_tail.valid, busy_ff,
      "beat left the chain with no request in flight")
   `UWT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff && !req_ready,
      "request accepted but block not marked busy")
   `UWT_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C,
      "entry count exceeds table depth")

endmodule

`default_nettype wire

FILE: hdl/uid_whitelist_table.sv
// ----------------------------------------------------------------------------
// uid_whitelist_table
// ordered table of card identifiers with a master entry in slot 0
// ----------------------------------------------------------------------------
// The req channel takes one beat of kind and card_id: lookup, store, remove
// (first match at slot 1 or higher, later entries close up) or clear all but
// the master. Each request gives exactly one rsp beat with the match flags
// taken before the operation, a status code and the entry count after it.
// The table is a row of TABLE_DEPTH cells, one slot each; a request travels
// down the row one cell per cycle, and the response is registered after it
// leaves the last cell. One request is in the row at a time: a new request
// is taken only once the last one has left the row.
// A waiting response does not block a new request as long as rsp_ready is
// high by the cycle of acceptance; while a response sits untaken, req_ready
// stays low. Reset clears every slot to zero and the count to zero and holds
// req_ready low; slot 0 then matches card_id zero as master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uid_whitelist_table
   import uwt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  [KIND_W-1:0]         req_kind,
   input  wire  [ID_W-1:0]           req_card_id,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic                      rsp_is_registered,
   output logic                      rsp_is_master,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ENTRY_COUNT_W-1:0]  rsp_entry_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   token_type       tok_chain   [TABLE_DEPTH+1];
   logic [ID_W-1:0] entry_chain [TABLE_DEPTH+1];
   logic [CW-1:0]   count;

   // past the last slot the chain reads as empty
   assign entry_chain[TABLE_DEPTH] = '0;

   uwt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_card_id       (req_card_id),
      .tok_head          (tok_chain[0]),
      .tok_tail          (tok_chain[TABLE_DEPTH]),
      .count             (count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_registered (rsp_is_registered),
      .rsp_is_master     (rsp_is_master),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      uwt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .count       (count),
         .prev_tok    (tok_chain[i]),
         .tok         (tok_chain[i+1]),
         .below_entry (entry_chain[i+1]),
         .entry       (entry_chain[i])
      );
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_uid_whitelist_table.sv
// ----------------------------------------------------------------------------
// tb_uid_whitelist_table
// self-checking bench for the uid whitelist table
// ----------------------------------------------------------------------------
// Drives lookup, store, remove and clear beats into the table and predicts
// every response from a shadow copy of the slots and the entry count. A
// directed opening covers the empty table, the master slot, filling up,
// duplicates and removal; random traffic over a small identifier pool
// follows, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uid_whitelist_table;
   import uwt_pkg::*;

   localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_ITEMS = 1900;
   localparam int QUIET_TAIL   = 200;
   localparam int STALL_LIMIT  = 1000;
   localparam int MAX_PRINTS   = 100;

   typedef struct {
      logic                     registered;
      logic                     master;
      status_type               status;
      logic [ENTRY_COUNT_W-1:0] count;
   } table_rsp_type;

   // shadow of the table, expected responses and mismatch accounting
   class whitelist_tracker;
      logic [ID_W-1:0] slots[DEPTH];
      int              used;
      table_rsp_type   awaited[$];
      int              mismatches;
      int              checked;
      int              full_hits;
      int              miss_hits;
      int              master_hits;
      int              peak_used;

      function new();
         foreach (slots[i]) slots[i] = '0;
         used        = 0;
         mismatches  = 0;
         checked     = 0;
         full_hits   = 0;
         miss_hits   = 0;
         master_hits = 0;
         peak_used   = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("[%0t] error: %s", $realtime, msg);
      endtask

      // apply one request to the shadow table and return its response
      function table_rsp_type apply(kind_type kind, logic [ID_W-1:0] id);
         table_rsp_type r;
         int            i;
         int            k;
         bit            hit;
         r.registered = 1'b0;
         for (i = 0; i < used && i < DEPTH; i++)
            if (slots[i] == id) r.registered = 1'b1;
         r.master = (slots[0] == id);
         r.status = STATUS_DONE;
         case (kind)
            KIND_STORE: begin
               if (used < DEPTH) begin
                  slots[used] = id;
                  used++;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
            KIND_REMOVE: begin
               hit = 1'b0;
               for (i = 1; i < used && !hit; i++) begin
                  if (slots[i] == id) begin
                     for (k = i; k + 1 < used; k++) slots[k] = slots[k + 1];
                     slots[k] = '0;
                     used--;
                     hit = 1'b1;
                  end
               end
               if (!hit) r.status = STATUS_NOT_FOUND;
            end
            KIND_CLEAR: begin
               for (i = 1; i < DEPTH; i++) slots[i] = '0;
               used = 1;
            end
            default: ;
         endcase
         r.count = used[ENTRY_COUNT_W-1:0];
         return r;
      endfunction

      function void note_request(kind_type kind, logic [ID_W-1:0] id);
         table_rsp_type r;
         r = apply(kind, id);
         if (r.status == STATUS_FULL) full_hits++;
         if (r.status == STATUS_NOT_FOUND) miss_hits++;
         if (r.master) master_hits++;
         if (used > peak_used) peak_used = used;
         awaited.push_back(r);
      endfunction

      task check_response(logic registered, logic master, logic [STATUS_W-1:0] status,
                          logic [ENTRY_COUNT_W-1:0] count);
         table_rsp_type e;
         if (awaited.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            e = awaited.pop_front();
            checked++;
            if (registered !== e.registered)
               report_mismatch($sformatf("is_registered got %b want %b",
                                         registered, e.registered));
            if (master !== e.master)
               report_mismatch($sformatf("is_master got %b want %b", master, e.master));
            if (status !== e.status)
               report_mismatch($sformatf("status got %0d want %0d", status, e.status));
            if (count !== e.count)
               report_mismatch($sformatf("entry_count got %0d want %0d", count, e.count));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   kind_type                 req_kind = KIND_LOOKUP;
   logic [ID_W-1:0]          req_card_id = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_is_registered;
   logic                     rsp_is_master;
   logic [STATUS_W-1:0]      rsp_status;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   whitelist_tracker tracker;
   bit               gaps_on = 1'b1;
   int               quiet_cycles = 0;
   int               rsp_stall_left = 0;
   int               sent_items = 0;
   logic [ID_W-1:0]  id_pool[8];

   uid_whitelist_table #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_card_id       (req_card_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_registered (rsp_is_registered),
      .rsp_is_master     (rsp_is_master),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // response side: random stall bursts while gaps are enabled
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // beat monitor; responses are checked before the new request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_is_registered, rsp_is_master, rsp_status,
                                   rsp_entry_count);
         if (req_valid && req_ready) tracker.note_request(req_kind, req_card_id);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_item(kind_type kind, logic [ID_W-1:0] id);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_card_id <= id;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   // hold the request side off until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(int clear_pct);
      int       pick;
      kind_type kind;
      logic [ID_W-1:0] id;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct)
         kind = KIND_CLEAR;
      else if (pick < 30)
         kind = KIND_LOOKUP;
      else if (pick < 66)
         kind = KIND_STORE;
      else
         kind = KIND_REMOVE;
      if ($urandom_range(0, 9) < 8)
         id = id_pool[$urandom_range(0, 7)];
      else
         id = $urandom();
      send_item(kind, id);
   endtask

   initial begin
      int i;
      int clear_pct;
      tracker = new();
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (i = 2; i < 8; i++) id_pool[i] = $urandom();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(KIND_LOOKUP, 32'h0000_0000);   // slot 0 is zero after reset
      send_item(KIND_REMOVE, 32'h0000_0000);   // nothing to remove yet
      send_item(KIND_CLEAR,  32'hffff_ffff);   // clear on an empty table
      send_item(KIND_LOOKUP, 32'h0000_0000);
      send_item(KIND_STORE,  32'hffff_ffff);
      send_item(KIND_STORE,  32'hffff_ffff);   // duplicate is appended again
      for (i = 0; i < 13; i++) send_item(KIND_STORE, 32'h1357_9bdf ^ (i * 32'h0101_0101));
      send_item(KIND_STORE,  32'ha5a5_5a5a);   // table full, ignored
      send_item(KIND_REMOVE, 32'h0000_0000);   // only the master matches
      send_item(KIND_REMOVE, 32'hffff_ffff);   // first of the duplicates
      send_item(KIND_REMOVE, 32'h1357_9bdf ^ (12 * 32'h0101_0101));
      send_item(KIND_LOOKUP, 32'hffff_ffff);
      send_item(KIND_CLEAR,  32'h0000_0000);
      wait_drained();

      // random traffic in phases with different clear rates
      clear_pct = 2;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) begin
            case ($urandom_range(0, 2))
               0: clear_pct = 0;
               1: clear_pct = 2;
               default: clear_pct = 8;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         if (i >= RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
         if (i == RANDOM_ITEMS / 2) wait_drained();
         send_random(clear_pct);
      end

      wait_drained();
      repeat (3 * (DEPTH + 1)) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report_mismatch($sformatf("%0d responses never arrived", tracker.pending()));

      $display("covered %0d requests, %0d responses checked, peak entries %0d",
               sent_items, tracker.checked, tracker.peak_used);
      $display("stores refused when full %0d, removes with no match %0d, master hits %0d",
               tracker.full_hits, tracker.miss_hits, tracker.master_hits);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
